### rtl/dense_graph_shortest_paths_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dense graph shortest paths block
// Each macro expects clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef DENSE_GRAPH_SHORTEST_PATHS_DEFINES_SVH
`define DENSE_GRAPH_SHORTEST_PATHS_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DGSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DGSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dgsp_pkg.sv
// ----------------------------------------------------------------------------
// dgsp_pkg
// Types and constants shared by the shortest path block and its parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dgsp_pkg;

    localparam int COST_W      = 20;
    localparam int WEIGHT_W    = 14;
    localparam int VC_W        = 5;
    localparam int VTX_W       = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 14;
    localparam int OUT_LIMIT   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_VERTEX_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_INFINITY_COST = 1'b1;

    localparam logic [VC_W-1:0]     VERTEX_COUNT_RESET = 5'd5;
    localparam logic [WEIGHT_W-1:0] INFINITY_RESET     = 14'd10000;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_RUN   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_PICK,
        ST_RELAX,
        ST_OUT
    } state_t;

    typedef logic [COST_W-1:0] cost_t;

    typedef struct packed {
        cost_t a;
        cost_t b;
        cost_t c;
    } alu_req_t;

    typedef struct packed {
        cost_t sum;
        logic  less;
    } alu_rsp_t;

endpackage

### rtl/dgsp_alu.sv
// ----------------------------------------------------------------------------
// dgsp_alu
// Shared add and compare unit: sum = a + b, less = (sum < c).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dgsp_alu (
    input  dgsp_pkg::alu_req_t req,
    output dgsp_pkg::alu_rsp_t rsp
);
    import dgsp_pkg::*;

    cost_t sum;

    assign sum      = req.a + req.b;
    assign rsp.sum  = sum;
    assign rsp.less = (sum < req.c);

endmodule

### rtl/dgsp_wmem.sv
// ----------------------------------------------------------------------------
// dgsp_wmem
// Weight matrix memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dgsp_wmem #(
    parameter int ADDR_W = 8
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [dgsp_pkg::WEIGHT_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [dgsp_pkg::WEIGHT_W-1:0] rd_data
);
    import dgsp_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [WEIGHT_W-1:0] mem_reg [DEPTH];
    logic [WEIGHT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/dense_graph_shortest_paths.sv
// ----------------------------------------------------------------------------
// dense_graph_shortest_paths
// A weight write leaves the block ready. A run over n vertices loads the
// distances, then for each picked vertex scans, picks and relaxes on one
// shared adder/comparator and one matrix read port, then makes n result transfers.
// Throughput: one run at a time; no item is taken until its last result is loaded.
// Reset loads vertex_count = 5, infinity_cost = 10000; the matrix is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dense_graph_shortest_paths #(
    parameter int MAX_VERTS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [dgsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dgsp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             func,
    input  logic [3:0]                       row,
    input  logic [3:0]                       col,
    input  logic [dgsp_pkg::WEIGHT_W-1:0]    edge_weight,
    input  logic [3:0]                       start_vertex,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dgsp_pkg::VTX_W-1:0]       vertex,
    output logic [dgsp_pkg::COST_W-1:0]      path_cost,
    output logic                             last
);
    import dgsp_pkg::*;

    localparam int LIM    = (MAX_VERTS < OUT_LIMIT) ? MAX_VERTS : OUT_LIMIT;
    localparam int VW     = $clog2(LIM);
    localparam int NW     = $clog2(LIM + 1);
    localparam int MEM_AW = 2 * VW;
    localparam logic [VC_W-1:0] LIM_VC = VC_W'(LIM);

    state_t state_reg, state_next;

    logic [VC_W-1:0]     vc_reg;
    logic [WEIGHT_W-1:0] inf_reg;

    logic [NW-1:0] n_reg;
    logic [VW-1:0] start_reg;
    logic          run_ok_reg;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] it_reg;
    logic [VW-1:0] pick_reg;
    cost_t         least_reg;
    logic          found_reg;
    logic          rd_vld_reg;
    logic [VW-1:0] rd_idx_reg;
    cost_t         best_reg [LIM];
    logic [LIM-1:0] visited_reg;

    logic             out_valid_reg;
    logic [VTX_W-1:0] out_vertex_reg;
    cost_t            out_cost_reg;
    logic             out_last_reg;

    logic          accept;
    logic          run_accept;
    logic [NW-1:0] n_calc;
    logic          start_ok;
    logic          mem_we;
    logic [WEIGHT_W-1:0] rd_data;
    logic [VW-1:0] cnt_idx;
    logic [VW-1:0] best_ra;
    cost_t         best_rd;
    logic          vis_rd;
    logic          issue;
    logic          cnt_at_n;
    logic          cnt_at_end;
    logic          more_picks;
    logic          out_load;
    cost_t         inf_cost;
    alu_req_t      alu_req;
    alu_rsp_t      alu_rsp;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg  <= VERTEX_COUNT_RESET;
            inf_reg <= INFINITY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VERTEX_COUNT:  vc_reg  <= cfg_data[VC_W-1:0];
                REG_INFINITY_COST: inf_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Decode of the input item and shared read points
    // ------------------------------------------------------------------
    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign run_accept = accept && (func == FUNC_RUN);
    assign inf_cost   = COST_W'(inf_reg);

    always_comb
    begin
        if (vc_reg == '0)
        begin
            n_calc = NW'(1);
        end
        else if (vc_reg > LIM_VC)
        begin
            n_calc = NW'(LIM);
        end
        else
        begin
            n_calc = NW'(vc_reg);
        end
    end

    assign start_ok = (VC_W'(start_vertex) < VC_W'(n_calc));
    assign mem_we   = accept && (func == FUNC_WRITE) &&
                      (VC_W'(row) < LIM_VC) && (VC_W'(col) < LIM_VC);

    assign cnt_idx    = cnt_reg[VW-1:0];
    assign cnt_at_n   = (cnt_reg == n_reg);
    assign cnt_at_end = (cnt_reg == NW'(n_reg - 1'b1));
    assign more_picks = (NW'(it_reg + 1'b1) < n_reg);
    assign issue      = ((state_reg == ST_INIT) || (state_reg == ST_RELAX)) &&
                        (cnt_reg < n_reg);
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // During relaxation the distance is read at the index whose weight returns.
    assign best_ra = (state_reg == ST_RELAX) ? rd_idx_reg : cnt_idx;
    assign best_rd = best_reg[best_ra];
    assign vis_rd  = visited_reg[best_ra];

    dgsp_wmem #(
        .ADDR_W (MEM_AW)
    ) u_wmem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr ({row[VW-1:0], col[VW-1:0]}),
        .wr_data (edge_weight),
        .rd_addr ({(state_reg == ST_INIT) ? start_reg : pick_reg, cnt_idx}),
        .rd_data (rd_data)
    );

    // Scan: is best[w] + 0 below the running minimum?
    // Relax: is least + weight below best[w]?
    always_comb
    begin
        if (state_reg == ST_RELAX)
        begin
            alu_req.a = least_reg;
            alu_req.b = COST_W'(rd_data);
            alu_req.c = best_rd;
        end
        else
        begin
            alu_req.a = best_rd;
            alu_req.b = '0;
            alu_req.c = least_reg;
        end
    end

    dgsp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (run_accept)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (cnt_at_n)
                begin
                    state_next = (!run_ok_reg || (n_reg == NW'(1))) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_at_end)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                state_next = found_reg ? ST_RELAX : ST_OUT;
            end
            ST_RELAX:
            begin
                if (cnt_at_n)
                begin
                    state_next = more_picks ? ST_SCAN : ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load && cnt_at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            it_reg        <= '0;
            found_reg     <= 1'b0;
            rd_vld_reg    <= 1'b0;
            run_ok_reg    <= 1'b0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= issue;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (run_accept)
                    begin
                        cnt_reg     <= '0;
                        visited_reg <= '0;
                        run_ok_reg  <= start_ok;
                    end
                end
                ST_INIT:
                begin
                    if (cnt_at_n)
                    begin
                        cnt_reg   <= '0;
                        it_reg    <= '0;
                        found_reg <= 1'b0;
                        if (run_ok_reg)
                        begin
                            visited_reg[start_reg] <= 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (!vis_rd && alu_rsp.less)
                    begin
                        found_reg <= 1'b1;
                    end
                    cnt_reg <= cnt_at_end ? '0 : cnt_reg + 1'b1;
                end
                ST_PICK:
                begin
                    cnt_reg <= '0;
                    if (found_reg)
                    begin
                        visited_reg[pick_reg] <= 1'b1;
                        it_reg                <= it_reg + 1'b1;
                    end
                end
                ST_RELAX:
                begin
                    if (cnt_at_n)
                    begin
                        cnt_reg   <= '0;
                        found_reg <= 1'b0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        cnt_reg <= cnt_at_end ? '0 : cnt_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Distances and result payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= cnt_idx;
        case (state_reg)
            ST_IDLE:
            begin
                if (run_accept)
                begin
                    n_reg     <= n_calc;
                    start_reg <= start_vertex[VW-1:0];
                end
            end
            ST_INIT:
            begin
                // The start vertex itself sits at distance zero.
                if (rd_vld_reg)
                begin
                    if (!run_ok_reg)
                    begin
                        best_reg[rd_idx_reg] <= inf_cost;
                    end
                    else if (rd_idx_reg == start_reg)
                    begin
                        best_reg[rd_idx_reg] <= '0;
                    end
                    else
                    begin
                        best_reg[rd_idx_reg] <= COST_W'(rd_data);
                    end
                end
                if (cnt_at_n)
                begin
                    least_reg <= inf_cost;
                end
            end
            ST_SCAN:
            begin
                if (!vis_rd && alu_rsp.less)
                begin
                    least_reg <= best_rd;
                    pick_reg  <= cnt_idx;
                end
            end
            ST_RELAX:
            begin
                if (rd_vld_reg && !vis_rd && alu_rsp.less)
                begin
                    best_reg[rd_idx_reg] <= alu_rsp.sum;
                end
                if (cnt_at_n)
                begin
                    least_reg <= inf_cost;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_vertex_reg <= VTX_W'(cnt_idx);
                    out_cost_reg   <= best_rd;
                    out_last_reg   <= cnt_at_end;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign vertex    = out_vertex_reg;
    assign path_cost = out_cost_reg;
    assign last      = out_last_reg;

endmodule

### rtl/dgsp_checker.sv
// ----------------------------------------------------------------------------
// dgsp_checker
// Port-level checks on the shortest path block, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dense_graph_shortest_paths_defines.svh"

module dgsp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             func,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [dgsp_pkg::VTX_W-1:0]       vertex,
    input logic [dgsp_pkg::COST_W-1:0]      path_cost,
    input logic                             last
);
    import dgsp_pkg::*;

    // A stalled result must hold its payload.
    `DGSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(vertex) && $stable(path_cost) && $stable(last), "stalled result changed")

    // A run transfer starts the search, so no further item is taken next cycle.
    `DGSP_ASSERT_NXT(a_run_busy, in_valid && in_ready && (func == FUNC_RUN), !in_ready, "ready after run transfer")

    // A weight write completes at once and leaves the block ready.
    `DGSP_ASSERT_NXT(a_write_ready, in_valid && in_ready && (func == FUNC_WRITE), in_ready, "not ready after weight write")

    // While results of a run remain, the block takes no new item.
    `DGSP_ASSERT_IMP(a_results_busy, out_valid && !last, !in_ready, "ready before last result")

endmodule

bind dense_graph_shortest_paths dgsp_checker u_dgsp_checker (.*);
